// ===== sv/ray_sphere_intersect_defines.svh =====
// Assertion helpers for the ray/sphere intersection block.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RSI_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define RSI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/rsi_pkg.sv =====
package rsi_pkg;

    // Control word that travels down the pipeline with each ray.
    typedef struct packed {
        logic valid;
        logic miss;
    } ctl_t;

endpackage

// ===== sv/rsi_if.sv =====
// Ray channel: origin and direction, signed fixed point.
interface rsi_ray_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

// Hit channel: hit flag and both root parameters.
interface rsi_hit_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] t_near;
    logic signed [COORD_WIDTH-1:0] t_far;

    modport source (
        output valid, hit, t_near, t_far,
        input  ready
    );
    modport sink (
        input  valid, hit, t_near, t_far,
        output ready
    );
endinterface

// ===== sv/ray_sphere_intersect.sv =====
// Ray against unit sphere at the origin, fully pipelined.
// Rays and roots are signed fixed point, Q16.16 at the default parameters.
// Throughput: one ray per cycle; the whole pipeline holds only while res waits.
// The square root and the two dividers set the depth: one result bit per stage.
// Reset (rst_n low, asynchronous) clears every valid bit; data registers keep garbage.
module ray_sphere_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rsi_ray_if.sink   ray,
    rsi_hit_if.source res
);
    localparam int W    = COORD_WIDTH;
    localparam int PW   = 2 * W;
    localparam int AW   = PW;
    localparam int HW   = PW + 1;
    localparam int CMW  = (PW > 2 * FRAC_BITS) ? PW : 2 * FRAC_BITS + 1;
    localparam int HHW  = 2 * PW;
    localparam int ACW  = AW + CMW;
    localparam int DMW  = ((HHW > ACW) ? HHW : ACW) + 1;
    localparam int DSW  = DMW + 1;
    localparam int SW   = (DMW + 1) / 2;
    localparam int NMW  = ((PW > SW) ? PW : SW) + 1;
    localparam int NSW  = NMW + 1;
    localparam int XW   = NMW + FRAC_BITS;
    localparam int SQW  = AW + PW + 1;

    localparam logic [CMW-1:0] ONE_SQ = CMW'(1) << (2 * FRAC_BITS);
    localparam logic [W-1:0]   MAXV   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MINV   = {1'b1, {(W-1){1'b0}}};

    logic adv;

    // Stage 1: products
    logic signed [PW-1:0] dd_x_reg, dd_y_reg, dd_z_reg;
    logic signed [PW-1:0] ho_x_reg, ho_y_reg, ho_z_reg;
    logic signed [PW-1:0] oo_x_reg, oo_y_reg, oo_z_reg;
    rsi_pkg::ctl_t        ctl1_reg;

    // Stage 2: dot products
    logic [AW-1:0] a2_reg, a2_next;
    logic [HW-1:0] h2_reg, h2_next;
    logic [PW-1:0] oo2_reg, oo2_next;
    rsi_pkg::ctl_t ctl2_reg;

    // Stage 3: magnitudes for the wide multipliers
    logic [AW-1:0]  a3_reg;
    logic [PW-1:0]  hmag3_reg, hmag3_next;
    logic           hneg3_reg;
    logic [CMW-1:0] cmag3_reg, cmag3_next, oo_ext;
    logic           cneg3_reg, cneg3_next;
    rsi_pkg::ctl_t  ctl3_reg, ctl3_next;

    // Stages 4 and 5: side data beside the multipliers
    logic [AW-1:0] a4_reg, a5_reg;
    logic [PW-1:0] hmag4_reg, hmag5_reg;
    logic          hneg4_reg, hneg5_reg, cneg4_reg, cneg5_reg;
    rsi_pkg::ctl_t ctl4_reg, ctl5_reg;
    logic [HHW-1:0] hh;
    logic [ACW-1:0] ac;

    // Stage 6: quarter discriminant
    logic [DSW-1:0] d_next;
    logic [DMW-1:0] d6_reg;
    logic [AW-1:0]  a6_reg;
    logic [PW-1:0]  hmag6_reg;
    logic           hneg6_reg;
    rsi_pkg::ctl_t  ctl6_reg, ctl6_next;

    // Square root outputs
    logic [SW-1:0]  sq_root;
    logic [SQW-1:0] sq_side;
    rsi_pkg::ctl_t  sq_ctl;
    logic [AW-1:0]  a_s;
    logic [PW-1:0]  hmag_s;
    logic           hneg_s;

    // Numerators
    logic [NSW-1:0] nh;
    logic [NSW-1:0] nnear_reg, nfar_reg;
    logic [AW-1:0]  an_reg;
    rsi_pkg::ctl_t  ctln_reg;

    // Shifted numerator magnitudes
    logic [XW-1:0]  xnear_reg, xfar_reg;
    logic           negnear_reg, negfar_reg;
    logic [AW-1:0]  ax_reg;
    rsi_pkg::ctl_t  ctlx_reg;
    logic [NMW-1:0] magnear, magfar;

    // Divider outputs
    logic [W-1:0]  q_near, q_far;
    logic [AW-1:0] r_near, r_far;
    logic          ovf_near, ovf_far;
    logic [0:0]    neg_near, neg_far;
    rsi_pkg::ctl_t ctl_near, ctl_far;

    // Output register
    logic          vout_reg;
    logic          hit_reg;
    logic [W-1:0]  t_near_reg, t_far_reg;
    logic [W-1:0]  t_near_next, t_far_next;

    // Floor quotient to signed Q value, with saturation
    function automatic logic [W-1:0] sat_root(
        input logic [W-1:0] q,
        input logic         rnz,
        input logic         ovf,
        input logic         neg
    );
        logic [W:0]   qr;
        logic         big;
        logic [W-1:0] r;
        qr  = {1'b0, q} + (W+1)'(rnz);
        big = ovf || qr[W] || (qr[W-1] && (qr[W-2:0] != '0));
        if (!neg)
        begin
            r = (ovf || q[W-1]) ? MAXV : q;
        end
        else
        begin
            r = big ? MINV : W'(-qr);
        end
        return r;
    endfunction

    // Hold everything while a finished result waits
    assign adv       = !vout_reg || res.ready;
    assign ray.ready = adv;

    // Stage 1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dd_x_reg <= ray.dir_x * ray.dir_x;
            dd_y_reg <= ray.dir_y * ray.dir_y;
            dd_z_reg <= ray.dir_z * ray.dir_z;
            ho_x_reg <= ray.dir_x * ray.origin_x;
            ho_y_reg <= ray.dir_y * ray.origin_y;
            ho_z_reg <= ray.dir_z * ray.origin_z;
            oo_x_reg <= ray.origin_x * ray.origin_x;
            oo_y_reg <= ray.origin_y * ray.origin_y;
            oo_z_reg <= ray.origin_z * ray.origin_z;
        end
    end

    // Stage 2
    assign a2_next  = $unsigned(dd_x_reg) + $unsigned(dd_y_reg) + $unsigned(dd_z_reg);
    assign h2_next  = HW'(ho_x_reg) + HW'(ho_y_reg) + HW'(ho_z_reg);
    assign oo2_next = $unsigned(oo_x_reg) + $unsigned(oo_y_reg) + $unsigned(oo_z_reg);

    // Stage 3: drop to sign and magnitude; a zero direction is a miss
    assign hmag3_next = h2_reg[HW-1] ? PW'(-h2_reg) : PW'(h2_reg);
    assign oo_ext     = CMW'(oo2_reg);
    assign cneg3_next = (oo_ext < ONE_SQ);
    assign cmag3_next = cneg3_next ? (ONE_SQ - oo_ext) : (oo_ext - ONE_SQ);
    always_comb
    begin
        ctl3_next      = ctl2_reg;
        ctl3_next.miss = ctl2_reg.miss || (a2_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg    <= a2_next;
            h2_reg    <= h2_next;
            oo2_reg   <= oo2_next;
            a3_reg    <= a2_reg;
            hmag3_reg <= hmag3_next;
            hneg3_reg <= h2_reg[HW-1];
            cmag3_reg <= cmag3_next;
            cneg3_reg <= cneg3_next;
            a4_reg    <= a3_reg;
            hmag4_reg <= hmag3_reg;
            hneg4_reg <= hneg3_reg;
            cneg4_reg <= cneg3_reg;
            a5_reg    <= a4_reg;
            hmag5_reg <= hmag4_reg;
            hneg5_reg <= hneg4_reg;
            cneg5_reg <= cneg4_reg;
        end
    end

    // Stages 4 and 5: H*H and A*|C|
    rsi_mul #(.NA(PW), .NB(PW)) u_mul_hh (
        .clk (clk),
        .en  (adv),
        .a   (hmag3_reg),
        .b   (hmag3_reg),
        .p   (hh)
    );

    rsi_mul #(.NA(AW), .NB(CMW)) u_mul_ac (
        .clk (clk),
        .en  (adv),
        .a   (a3_reg),
        .b   (cmag3_reg),
        .p   (ac)
    );

    // Stage 6: D = H*H - A*C; a negative D is a miss
    assign d_next = cneg5_reg ? (DSW'(hh) + DSW'(ac)) : (DSW'(hh) - DSW'(ac));
    always_comb
    begin
        ctl6_next      = ctl5_reg;
        ctl6_next.miss = ctl5_reg.miss || d_next[DSW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d6_reg    <= d_next[DMW-1:0];
            a6_reg    <= a5_reg;
            hmag6_reg <= hmag5_reg;
            hneg6_reg <= hneg5_reg;
        end
    end

    rsi_sqrt #(.IN_W(DMW), .SIDE_W(SQW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .radicand (d6_reg),
        .side_in  ({a6_reg, hmag6_reg, hneg6_reg}),
        .ctl_in   (ctl6_reg),
        .root     (sq_root),
        .side_out (sq_side),
        .ctl_out  (sq_ctl)
    );

    assign a_s    = sq_side[SQW-1 -: AW];
    assign hmag_s = sq_side[PW:1];
    assign hneg_s = sq_side[0];

    // Numerators -H - S and -H + S
    assign nh = hneg_s ? NSW'(hmag_s) : (NSW'(0) - NSW'(hmag_s));

    // Magnitudes for the dividers
    assign magnear = nnear_reg[NSW-1] ? NMW'(-nnear_reg) : NMW'(nnear_reg);
    assign magfar  = nfar_reg[NSW-1]  ? NMW'(-nfar_reg)  : NMW'(nfar_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nnear_reg   <= nh - NSW'(sq_root);
            nfar_reg    <= nh + NSW'(sq_root);
            an_reg      <= a_s;
            xnear_reg   <= {magnear, {FRAC_BITS{1'b0}}};
            xfar_reg    <= {magfar, {FRAC_BITS{1'b0}}};
            negnear_reg <= nnear_reg[NSW-1];
            negfar_reg  <= nfar_reg[NSW-1];
            ax_reg      <= an_reg;
        end
    end

    rsi_div #(.X_W(XW), .DIV_W(AW), .Q_W(W), .SIDE_W(1)) u_div_near (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .dividend (xnear_reg),
        .divisor  (ax_reg),
        .side_in  (negnear_reg),
        .ctl_in   (ctlx_reg),
        .quot     (q_near),
        .rem      (r_near),
        .ovf      (ovf_near),
        .side_out (neg_near),
        .ctl_out  (ctl_near)
    );

    rsi_div #(.X_W(XW), .DIV_W(AW), .Q_W(W), .SIDE_W(1)) u_div_far (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .dividend (xfar_reg),
        .divisor  (ax_reg),
        .side_in  (negfar_reg),
        .ctl_in   (ctlx_reg),
        .quot     (q_far),
        .rem      (r_far),
        .ovf      (ovf_far),
        .side_out (neg_far),
        .ctl_out  (ctl_far)
    );

    // Round toward minus infinity, saturate, zero on a miss
    assign t_near_next = ctl_far.miss ? '0
                       : sat_root(q_near, (r_near != '0), ovf_near, neg_near[0]);
    assign t_far_next  = ctl_far.miss ? '0
                       : sat_root(q_far, (r_far != '0), ovf_far, neg_far[0]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg    <= !ctl_far.miss;
            t_near_reg <= t_near_next;
            t_far_reg  <= t_far_next;
        end
    end

    // Control words and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctln_reg <= '0;
            ctlx_reg <= '0;
            vout_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl1_reg.valid <= ray.valid;
            ctl1_reg.miss  <= 1'b0;
            ctl2_reg       <= ctl1_reg;
            ctl3_reg       <= ctl3_next;
            ctl4_reg       <= ctl3_reg;
            ctl5_reg       <= ctl4_reg;
            ctl6_reg       <= ctl6_next;
            ctln_reg       <= sq_ctl;
            ctlx_reg       <= ctln_reg;
            vout_reg       <= ctl_near.valid;
        end
    end

    assign res.valid  = vout_reg;
    assign res.hit    = hit_reg;
    assign res.t_near = t_near_reg;
    assign res.t_far  = t_far_reg;
endmodule

// ===== sv/rsi_mul.sv =====
// Two-stage unsigned multiplier: four half-width partial products, then the sum.
module rsi_mul #(
    parameter int NA = 64,
    parameter int NB = 64
) (
    input  logic              clk,
    input  logic              en,
    input  logic [NA-1:0]     a,
    input  logic [NB-1:0]     b,
    output logic [NA+NB-1:0]  p
);
    localparam int LA = NA / 2;
    localparam int HA = NA - LA;
    localparam int LB = NB / 2;
    localparam int HB = NB - LB;
    localparam int PW = NA + NB;

    logic [LA+LB-1:0] pp_ll_reg;
    logic [LA+HB-1:0] pp_lh_reg;
    logic [HA+LB-1:0] pp_hl_reg;
    logic [HA+HB-1:0] pp_hh_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    // Form the partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= a[LA-1:0]  * b[LB-1:0];
            pp_lh_reg <= a[LA-1:0]  * b[NB-1:LB];
            pp_hl_reg <= a[NA-1:LA] * b[LB-1:0];
            pp_hh_reg <= a[NA-1:LA] * b[NB-1:LB];
        end
    end

    // Align and add them
    assign p_next = (PW'(pp_hh_reg) << (LA + LB)) + (PW'(pp_hl_reg) << LA)
                  + (PW'(pp_lh_reg) << LB) + PW'(pp_ll_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;
endmodule

// ===== sv/rsi_sqrt.sv =====
// Pipelined integer square root, one root bit per stage (restoring digit method).
module rsi_sqrt #(
    parameter int IN_W   = 129,
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [IN_W-1:0]           radicand,
    input  logic [SIDE_W-1:0]         side_in,
    input  rsi_pkg::ctl_t             ctl_in,
    output logic [(IN_W+1)/2-1:0]     root,
    output logic [SIDE_W-1:0]         side_out,
    output rsi_pkg::ctl_t             ctl_out
);
    localparam int ROOT_W = (IN_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [PAD_W-1:0]  rad_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    rsi_pkg::ctl_t     ctl_reg  [ROOT_W];

    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [PAD_W-1:0]  rad_next  [ROOT_W];

    // Each stage brings down two radicand bits and tries the next root bit
    always_comb
    begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              ge;
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (i == 0)
            begin
                rem_in      = '0;
                root_in     = '0;
                rad_next[i] = PAD_W'(radicand);
            end
            else
            begin
                rem_in      = rem_reg[i-1];
                root_in     = root_reg[i-1];
                rad_next[i] = rad_reg[i-1];
            end
            cur          = {rem_in, rad_next[i][2*(ROOT_W-1-i)+1 -: 2]};
            trial        = (REM_W+2)'({root_in, 2'b01});
            ge           = (cur >= trial);
            rem_next[i]  = ge ? REM_W'(cur - trial) : REM_W'(cur);
            root_next[i] = {root_in[ROOT_W-2:0], ge};
        end
    end

    // Advance the data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 0; i < ROOT_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
                if (i > 0)
                begin
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end
    end

    // Advance the control words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < ROOT_W; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];
    assign ctl_out  = ctl_reg[ROOT_W-1];
endmodule

// ===== sv/rsi_div.sv =====
// Pipelined restoring divider: an overflow test stage, then one quotient bit per stage.
module rsi_div #(
    parameter int X_W    = 82,
    parameter int DIV_W  = 64,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [X_W-1:0]    dividend,
    input  logic [DIV_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side_in,
    input  rsi_pkg::ctl_t     ctl_in,
    output logic [Q_W-1:0]    quot,
    output logic [DIV_W-1:0]  rem,
    output logic              ovf,
    output logic [SIDE_W-1:0] side_out,
    output rsi_pkg::ctl_t     ctl_out
);
    localparam int HI_W  = X_W - Q_W;
    localparam int CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;
    localparam int NST   = Q_W + 1;

    logic [DIV_W-1:0]  rem_reg  [NST];
    logic [Q_W-1:0]    q_reg    [NST];
    logic [Q_W-1:0]    xlo_reg  [NST];
    logic [DIV_W-1:0]  dvs_reg  [NST];
    logic              ovf_reg  [NST];
    logic [SIDE_W-1:0] side_reg [NST];
    rsi_pkg::ctl_t     ctl_reg  [NST];

    logic [DIV_W-1:0]  rem_next [NST];
    logic [Q_W-1:0]    q_next   [NST];
    logic              ovf_next;

    // Quotient reaches 2^Q_W exactly when the upper dividend bits reach the divisor
    assign ovf_next = (CMP_W'(dividend[X_W-1:Q_W]) >= CMP_W'(divisor));

    // Shift in one dividend bit per stage and subtract where it fits
    always_comb
    begin
        logic [DIV_W:0] cur;
        logic           ge;
        rem_next[0] = DIV_W'(dividend[X_W-1:Q_W]);
        q_next[0]   = '0;
        for (int j = 1; j < NST; j++)
        begin
            cur         = {rem_reg[j-1], xlo_reg[j-1][Q_W-j]};
            ge          = (cur >= {1'b0, dvs_reg[j-1]});
            rem_next[j] = ge ? DIV_W'(cur - {1'b0, dvs_reg[j-1]}) : DIV_W'(cur);
            q_next[j]   = {q_reg[j-1][Q_W-2:0], ge};
        end
    end

    // Advance the data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xlo_reg[0]  <= dividend[Q_W-1:0];
            dvs_reg[0]  <= divisor;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side_in;
            for (int j = 0; j < NST; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                if (j > 0)
                begin
                    xlo_reg[j]  <= xlo_reg[j-1];
                    dvs_reg[j]  <= dvs_reg[j-1];
                    ovf_reg[j]  <= ovf_reg[j-1];
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end
    end

    // Advance the control words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NST; j++)
            begin
                ctl_reg[j] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int j = 1; j < NST; j++)
            begin
                ctl_reg[j] <= ctl_reg[j-1];
            end
        end
    end

    assign quot     = q_reg[NST-1];
    assign rem      = rem_reg[NST-1];
    assign ovf      = ovf_reg[NST-1];
    assign side_out = side_reg[NST-1];
    assign ctl_out  = ctl_reg[NST-1];
endmodule

// ===== sv/rsi_checker.sv =====
`include "ray_sphere_intersect_defines.svh"

// Port-level checks on the result channel.
module rsi_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   out_hit,
    input logic [COORD_WIDTH-1:0] out_t_near,
    input logic [COORD_WIDTH-1:0] out_t_far
);
    // Hold a stalled transaction
    `RSI_ASSERT_RUN(a_valid_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `RSI_ASSERT_RUN(a_data_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_hit) && $stable(out_t_near) && $stable(out_t_far), "result changed while stalled")

    // A miss carries zero roots; a hit has the near root first
    `RSI_ASSERT_RUN(a_miss_zero, clk, rst_n, out_valid && !out_hit |-> out_t_near == '0 && out_t_far == '0, "miss with nonzero roots")
    `RSI_ASSERT_RUN(a_root_order, clk, rst_n, out_valid && out_hit |-> $signed(out_t_near) <= $signed(out_t_far), "near root above far root")

    // Nothing comes out during reset
    `RSI_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid, "result valid during reset")
endmodule

bind ray_sphere_intersect rsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rsi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_hit    (res.hit),
    .out_t_near (res.t_near),
    .out_t_far  (res.t_far)
);
